// ===== rtl/core/kfpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfpc_pkg
// shared types, codes and constants of the keypad fixed-point calculator
// ----------------------------------------------------------------------------
package kfpc_pkg;

	// entry limits and widths
	localparam int RAW_W = 20;                       // raw entry up to the entry limit
	localparam int OPD_W = 27;                       // operand in hundredths
	localparam int VAL_W = 48;                       // shown value
	localparam int PRD_W = 2 * OPD_W;                // full product / aligned dividend
	localparam int A100_W = 34;                      // operand times one hundred
	localparam int CNT_W = 6;
	localparam logic [23:0] MAX_ENTRY = 24'd999999;

	// serial step counts
	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(OPD_W);
	localparam logic [CNT_W-1:0] DIV100_STEPS = CNT_W'(PRD_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(A100_W);
	localparam logic [OPD_W-1:0] HUNDRED = OPD_W'(100);

	// display kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_FIRST = 3'd1;
	localparam logic [2:0] KIND_SECOND = 3'd2;
	localparam logic [2:0] KIND_RESULT = 3'd3;
	localparam logic [2:0] KIND_DIVZERO = 3'd4;

	// pending operators
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// special keys
	localparam logic [3:0] KEY_POINT = 4'd12;
	localparam logic [3:0] KEY_EQUALS = 4'd14;

	// request to the serial multiply / divide unit
	typedef struct packed {
		logic             start;
		logic             is_div;
		logic [OPD_W-1:0] a;
		logic [OPD_W-1:0] b;
	} kfpc_alu_req_t;

	// answer of the serial unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] quotient;
	} kfpc_alu_rsp_t;

	// digit value of a key; bit 4 set when the key is not a digit
	function automatic logic [4:0] digit_of(input logic [3:0] key);
		logic [4:0] d;
		unique case (key)
			4'd0:    d = 5'd1;
			4'd1:    d = 5'd2;
			4'd2:    d = 5'd3;
			4'd4:    d = 5'd4;
			4'd5:    d = 5'd5;
			4'd6:    d = 5'd6;
			4'd8:    d = 5'd7;
			4'd9:    d = 5'd8;
			4'd10:   d = 5'd9;
			4'd13:   d = 5'd0;
			default: d = 5'h10;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/kfpc_serial_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfpc_serial_alu
// bit-serial multiply then divide by one hundred, or a*100 / b
// ----------------------------------------------------------------------------
module kfpc_serial_alu
	import kfpc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  kfpc_alu_req_t req,
	output kfpc_alu_rsp_t rsp
);

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV
	} ust_t;

	ust_t             ust_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OPD_W:0]   hi_q;     // partial product high half / remainder
	logic [PRD_W-1:0] lo_q;     // multiplier and product low half / dividend and quotient
	logic [OPD_W-1:0] mcand_q;  // multiplicand / divisor
	logic             done_q;

	logic [OPD_W:0]    mul_sum;
	logic [OPD_W:0]    div_shift;
	logic              div_ge;
	logic [A100_W-1:0] a100;

	always_comb begin
		mul_sum = hi_q + (lo_q[0] ? {1'b0, mcand_q} : '0);
		div_shift = {hi_q[OPD_W-1:0], lo_q[PRD_W-1]};
		div_ge = div_shift >= {1'b0, mcand_q};
		a100 = A100_W'({req.a, 6'b0}) + A100_W'({req.a, 5'b0}) + A100_W'({req.a, 2'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q <= U_IDLE;
			cnt_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			mcand_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ust_q)
				U_IDLE: begin
					if (req.start) begin
						hi_q <= '0;
						if (req.is_div) begin
							lo_q <= {a100, (PRD_W - A100_W)'(0)};
							mcand_q <= req.b;
							cnt_q <= DIV_STEPS;
							ust_q <= U_DIV;
						end else begin
							lo_q <= PRD_W'(req.b);
							mcand_q <= req.a;
							cnt_q <= MUL_STEPS;
							ust_q <= U_MUL;
						end
					end
				end
				U_MUL: begin
					// add-and-shift-right, one multiplier bit a cycle
					if (cnt_q == CNT_W'(1)) begin
						lo_q <= {mul_sum[OPD_W:1], mul_sum[0], lo_q[OPD_W-1:1]};
						hi_q <= '0;
						mcand_q <= HUNDRED;
						cnt_q <= DIV100_STEPS;
						ust_q <= U_DIV;
					end else begin
						hi_q <= {1'b0, mul_sum[OPD_W:1]};
						lo_q <= {lo_q[PRD_W-1:OPD_W], mul_sum[0], lo_q[OPD_W-1:1]};
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				U_DIV: begin
					// restoring division, one quotient bit a cycle
					hi_q <= div_ge ? div_shift - {1'b0, mcand_q} : div_shift;
					lo_q <= {lo_q[PRD_W-2:0], div_ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						done_q <= 1'b1;
						ust_q <= U_IDLE;
					end
				end
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.busy = ust_q != U_IDLE;
	assign rsp.done = done_q;
	assign rsp.quotient = lo_q[VAL_W-1:0];

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(ust_q != U_IDLE) |-> (cnt_q != '0))
		else $error("serial unit running with an empty step count");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (ust_q == U_IDLE))
		else $error("serial unit started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

endmodule

// ===== rtl/core/keypad_fixed_point_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_fixed_point_calculator
// keypad-driven two-operand calculator working in hundredths
// ----------------------------------------------------------------------------
// One key press comes in per slave transfer and exactly one display update
// goes out per press on the master side. Digits, point, operators, add and
// subtract register their answer in the pending-answer registers, which then
// load the output register. Equals with multiply first runs 27 multiply steps
// and 54 steps of the divide by one hundred in the bit-serial unit; equals with
// divide first runs 34 restoring-division steps there. The input is taken again
// once the answer sits in the output register, so a new press can be accepted
// while the previous display update still waits on m_tready. Results are in
// hundredths; divide truncates toward zero and a zero divisor reports the
// division-by-zero kind with a zero value.
// ----------------------------------------------------------------------------
module keypad_fixed_point_calculator
	import kfpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// key press stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [4:1] key, [7:5] zero
	// display update stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [47:0] shown_value, [49:48] operation,
	                               // [50] point_active, [55:51] zero
	output logic [2:0]  m_tuser    // [2:0] display_kind
);

	typedef enum logic [2:0] {
		PH_WAIT1,
		PH_IN1,
		PH_WAIT2,
		PH_IN2,
		PH_RESULT
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_HOLD
	} st_t;

	// calculator state
	phase_t           phase_q;
	logic [OPD_W-1:0] left_q;
	logic [OPD_W-1:0] right_q;
	logic [1:0]       op_q;
	logic             point_q;
	logic [1:0]       frac_q;

	// sequencing and pending answer
	st_t              st_q;
	logic [2:0]       res_kind_q;
	logic [VAL_W-1:0] res_val_q;
	logic [1:0]       res_op_q;
	logic             res_pt_q;

	// next-state values
	phase_t           phase_d;
	logic [OPD_W-1:0] left_d;
	logic [OPD_W-1:0] right_d;
	logic [1:0]       op_d;
	logic             point_d;
	logic [1:0]       frac_d;
	logic [2:0]       kind_d;
	logic [VAL_W-1:0] val_d;
	logic [1:0]       rop_d;
	logic             rpt_d;
	logic             alu_go;

	logic             restart;
	logic [3:0]       key;
	logic [4:0]       dig;
	logic             is_digit;
	logic             is_op;
	logic [RAW_W-1:0] cur_raw;
	logic [23:0]      grown;
	logic             grow_ok;
	logic [RAW_W-1:0] new_raw;
	logic [1:0]       new_frac;
	logic [OPD_W-1:0] scaled;
	logic [28:0]      sum29;
	logic [28:0]      dif29;
	logic             in_xfer;
	logic             out_load;

	kfpc_alu_req_t alu_req;
	kfpc_alu_rsp_t alu_rsp;

	assign restart = s_tdata[0];
	assign key = s_tdata[4:1];
	assign s_tready = st_q == ST_IDLE;
	assign in_xfer = s_tvalid && s_tready;
	assign out_load = (st_q == ST_HOLD) && (!m_tvalid || m_tready);

	// entry growth and scaling of the operand being typed
	always_comb begin
		dig = digit_of(key);
		is_digit = !dig[4];
		is_op = key[1:0] == 2'b11;
		cur_raw = (phase_q == PH_IN2) ? right_q[RAW_W-1:0] : left_q[RAW_W-1:0];
		grown = 24'({cur_raw, 3'b0}) + 24'({cur_raw, 1'b0}) + 24'(dig[3:0]);
		// no third fraction digit, no entry past the limit
		grow_ok = !(point_q && frac_q >= 2'd2) && (grown <= MAX_ENTRY);
		new_raw = grow_ok ? grown[RAW_W-1:0] : cur_raw;
		new_frac = (grow_ok && point_q) ? frac_q + 2'd1 : frac_q;
		// a point with no fraction digits scales like no point at all
		if (point_q && frac_q == 2'd2) begin
			scaled = OPD_W'(cur_raw);
		end else if (point_q && frac_q == 2'd1) begin
			scaled = OPD_W'({cur_raw, 3'b0}) + OPD_W'({cur_raw, 1'b0});
		end else begin
			scaled = OPD_W'({cur_raw, 6'b0}) + OPD_W'({cur_raw, 5'b0})
				+ OPD_W'({cur_raw, 2'b0});
		end
		sum29 = 29'(left_q) + 29'(scaled);
		dif29 = 29'(left_q) - 29'(scaled);
	end

	// key decode and calculator transition
	always_comb begin
		phase_d = phase_q;
		left_d = left_q;
		right_d = right_q;
		op_d = op_q;
		point_d = point_q;
		frac_d = frac_q;
		kind_d = KIND_NONE;
		val_d = '0;
		rop_d = '0;
		rpt_d = 1'b0;
		alu_go = 1'b0;

		if (restart) begin
			phase_d = PH_WAIT1;
			left_d = '0;
			right_d = '0;
			op_d = OP_ADD;
			point_d = 1'b0;
			frac_d = '0;
		end else if (key == KEY_POINT) begin
			if (phase_q == PH_IN1 || phase_q == PH_IN2) begin
				// a repeated point restarts the fraction count
				point_d = 1'b1;
				frac_d = '0;
				kind_d = (phase_q == PH_IN1) ? KIND_FIRST : KIND_SECOND;
				val_d = VAL_W'(cur_raw);
				rop_d = op_q;
				rpt_d = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_WAIT1, PH_WAIT2: begin
					if (is_digit) begin
						point_d = 1'b0;
						frac_d = '0;
						val_d = VAL_W'(dig[3:0]);
						rop_d = op_q;
						if (phase_q == PH_WAIT1) begin
							left_d = OPD_W'(dig[3:0]);
							phase_d = PH_IN1;
							kind_d = KIND_FIRST;
						end else begin
							right_d = OPD_W'(dig[3:0]);
							phase_d = PH_IN2;
							kind_d = KIND_SECOND;
						end
					end
				end
				PH_IN1: begin
					if (is_digit) begin
						left_d = OPD_W'(new_raw);
						frac_d = new_frac;
						kind_d = KIND_FIRST;
						val_d = VAL_W'(new_raw);
						rop_d = op_q;
						rpt_d = point_q;
					end else if (is_op) begin
						// shows the raw entry, stores it in hundredths
						left_d = scaled;
						op_d = key[3:2];
						point_d = 1'b0;
						frac_d = '0;
						phase_d = PH_WAIT2;
						kind_d = KIND_FIRST;
						val_d = VAL_W'(cur_raw);
						rop_d = key[3:2];
					end
				end
				PH_IN2: begin
					if (is_digit) begin
						right_d = OPD_W'(new_raw);
						frac_d = new_frac;
						kind_d = KIND_SECOND;
						val_d = VAL_W'(new_raw);
						rop_d = op_q;
						rpt_d = point_q;
					end else if (key == KEY_EQUALS) begin
						right_d = scaled;
						point_d = 1'b0;
						frac_d = '0;
						phase_d = PH_RESULT;
						rop_d = op_q;
						kind_d = KIND_RESULT;
						case (op_q)
							OP_ADD: val_d = {{(VAL_W - 29){sum29[28]}}, sum29};
							OP_SUB: val_d = {{(VAL_W - 29){dif29[28]}}, dif29};
							OP_MUL: alu_go = 1'b1;
							default: begin
								if (scaled == '0) begin
									kind_d = KIND_DIVZERO;
								end else begin
									alu_go = 1'b1;
								end
							end
						endcase
					end
				end
				PH_RESULT: begin
					// a digit after a result starts over, shown as no change
					if (is_digit) begin
						phase_d = PH_WAIT1;
						left_d = '0;
						right_d = '0;
						op_d = OP_ADD;
						point_d = 1'b0;
						frac_d = '0;
					end
				end
				default: phase_d = PH_WAIT1;
			endcase
		end
	end

	assign alu_req.start = in_xfer && alu_go;
	assign alu_req.is_div = op_q == OP_DIV;
	assign alu_req.a = left_q;
	assign alu_req.b = scaled;

	kfpc_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT1;
			left_q <= '0;
			right_q <= '0;
			op_q <= OP_ADD;
			point_q <= 1'b0;
			frac_q <= '0;
			st_q <= ST_IDLE;
			res_kind_q <= KIND_NONE;
			res_val_q <= '0;
			res_op_q <= '0;
			res_pt_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= KIND_NONE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						phase_q <= phase_d;
						left_q <= left_d;
						right_q <= right_d;
						op_q <= op_d;
						point_q <= point_d;
						frac_q <= frac_d;
						res_kind_q <= kind_d;
						res_val_q <= val_d;
						res_op_q <= rop_d;
						res_pt_q <= rpt_d;
						st_q <= alu_go ? ST_CALC : ST_HOLD;
					end
				end
				ST_CALC: begin
					if (alu_rsp.done) begin
						res_val_q <= alu_rsp.quotient;
						st_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase

			// output register: loaded when empty or being drained
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata <= {5'b0, res_pt_q, res_op_q, res_val_q};
				m_tuser <= res_kind_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	a_calc_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CALC && alu_rsp.done) |=> (st_q == ST_HOLD))
		else $error("serial answer not moved to the output stage");

	a_point_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT1 || phase_q == PH_WAIT2 || phase_q == PH_RESULT) |-> !point_q)
		else $error("point flag set outside operand entry");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_NONE) |-> (m_tdata == '0))
		else $error("no-change update carries a payload");

	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CALC) |-> (alu_rsp.busy || alu_rsp.done))
		else $error("waiting on an idle serial unit");

endmodule
